/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and synchronous reset
`define BPR_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset
`define BPR_ASSERT(label, prop, msg) \
   `BPR_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

/* rtl/bpr_pkg.sv */
`timescale 1ns / 1ps
package bpr_pkg;

   localparam int FRAMES_DEF   = 8;
   localparam int KEY_BITS_DEF = 16;
   localparam int TOTAL_BITS   = 32;

   typedef enum logic [1:0] {
      POL_FIFO  = 2'd0,
      POL_LRU   = 2'd1,
      POL_MRU   = 2'd2,
      POL_CLOCK = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      OUT_HIT       = 2'd0,
      OUT_LOADED    = 2'd1,
      OUT_NOT_FOUND = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP,
      ST_EV_READ,
      ST_EV_WRITE
   } state_type;

   typedef enum logic [1:0] {
      LIST_NONE,
      LIST_REMOVE,
      LIST_APPEND
   } list_op_type;

endpackage

/* rtl/bpr_frame_store.sv */
`timescale 1ns / 1ps
module bpr_frame_store #(
   parameter int FRAMES   = 8,
   parameter int KEY_BITS = 16,
   localparam int FI_W    = $clog2(FRAMES)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [FI_W-1:0]     wr_addr,
   input  logic [KEY_BITS-1:0] wr_key,
   input  logic                wr_dirty,
   input  logic [FI_W-1:0]     rd_addr,
   output logic [KEY_BITS-1:0] rd_key,
   output logic                rd_dirty
);

   logic [KEY_BITS:0] mem [FRAMES];
   logic [KEY_BITS:0] rd_data_ff;

   // write key and dirty bit of a loaded page
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_dirty};
      end
   end

   // registered read of the victim entry
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_key   = rd_data_ff[KEY_BITS:1];
   assign rd_dirty = rd_data_ff[0];

endmodule

/* rtl/bpr_order_list.sv */
`timescale 1ns / 1ps
module bpr_order_list
   import bpr_pkg::*;
#(
   parameter int FRAMES = 8,
   localparam int FI_W  = $clog2(FRAMES)
) (
   input  logic            clock,
   input  logic            reset,
   input  list_op_type     op,
   input  logic [FI_W-1:0] frame,
   output logic [FI_W-1:0] head,
   output logic [FI_W-1:0] tail,
   output logic            empty
);

   logic            in_list_ff [FRAMES];
   logic            in_list_in [FRAMES];
   logic [FI_W-1:0] rank_ff    [FRAMES];
   logic [FI_W-1:0] rank_in    [FRAMES];
   logic [FI_W:0]   count_ff;
   logic [FI_W:0]   count_in;

   // remove the frame, close the gap, then append at the tail if asked
   always_comb begin
      logic            present;
      logic [FI_W-1:0] rm_rank;
      logic [FI_W:0]   cnt_rm;
      present = in_list_ff[frame];
      rm_rank = rank_ff[frame];
      cnt_rm  = count_ff - {{FI_W{1'b0}}, (present && op != LIST_NONE)};
      count_in = count_ff;
      for (int j = 0; j < FRAMES; j++) begin
         in_list_in[j] = in_list_ff[j];
         rank_in[j]    = rank_ff[j];
         if (op != LIST_NONE) begin
            if (present && in_list_ff[j] && rank_ff[j] > rm_rank) begin
               rank_in[j] = rank_ff[j] - 1'b1;
            end
            if (frame == FI_W'(j)) begin
               in_list_in[j] = 1'b0;
            end
         end
      end
      if (op != LIST_NONE) begin
         count_in = cnt_rm;
      end
      if (op == LIST_APPEND) begin
         in_list_in[frame] = 1'b1;
         rank_in[frame]    = cnt_rm[FI_W-1:0];
         count_in          = cnt_rm + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int j = 0; j < FRAMES; j++) begin
            in_list_ff[j] <= 1'b0;
         end
      end else begin
         count_ff <= count_in;
         for (int j = 0; j < FRAMES; j++) begin
            in_list_ff[j] <= in_list_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < FRAMES; j++) begin
         rank_ff[j] <= rank_in[j];
      end
   end

   // find oldest and newest entries
   always_comb begin
      logic [FI_W:0] last;
      last = count_ff - 1'b1;
      head = '0;
      tail = '0;
      for (int j = 0; j < FRAMES; j++) begin
         if (in_list_ff[j] && rank_ff[j] == '0) begin
            head = FI_W'(j);
         end
         if (in_list_ff[j] && rank_ff[j] == last[FI_W-1:0]) begin
            tail = FI_W'(j);
         end
      end
   end

   assign empty = (count_ff == '0);

endmodule

/* rtl/buffer_pool_replacement.sv */
`timescale 1ns / 1ps
// Page frame table with FIFO, LRU, MRU or CLOCK replacement. A request is
// taken when start is high and busy is low; its one result appears on the
// rsp_ ports for exactly one cycle with rsp_valid high and must be taken
// then, since the receiver cannot stall. A hit, a not-found miss or a load
// into an empty frame keeps busy high in the lookup state only. A load with
// eviction under FIFO, LRU or MRU keeps it high through the lookup, eviction
// read and eviction write states, set by the registered read of the victim's
// key and dirty bit from the frame store. Under CLOCK the sweep inspects one
// frame per cycle and may clear up to FRAMES reference bits before it finds
// a clear one, so an evicting request also keeps busy high through the
// sweep. The next request may be accepted at the edge that ends the cycle in
// which its predecessor's result is shown. A policy write takes effect with
// the next request only if the user writes it while busy is low; the block
// does not enforce this. Order list and reference bits are kept.
module buffer_pool_replacement
   import bpr_pkg::*;
#(
   parameter int FRAMES   = FRAMES_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF,
   localparam int FI_W    = $clog2(FRAMES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [KEY_BITS-1:0]   req_page_key,
   input  logic                  req_page_exists,
   input  logic                  req_dirty_mark,
   input  logic                  csr_we,
   input  logic [1:0]            csr_wdata,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_outcome,
   output logic [FI_W-1:0]       rsp_frame_index,
   output logic                  rsp_evicted,
   output logic [KEY_BITS-1:0]   rsp_evicted_key,
   output logic                  rsp_evicted_dirty,
   output logic [TOTAL_BITS-1:0] rsp_hit_total,
   output logic [TOTAL_BITS-1:0] rsp_miss_total
);

   state_type state_ff, state_in;
   policy_type policy_ff;

   logic [KEY_BITS-1:0] key_ff;
   logic                exists_ff;
   logic                dirty_ff;

   logic                valid_ff [FRAMES];
   logic                valid_in [FRAMES];
   logic                ref_ff   [FRAMES];
   logic                ref_in   [FRAMES];
   logic [KEY_BITS-1:0] cam_ff   [FRAMES];

   logic [FI_W-1:0]       hand_ff, hand_in, hand_next;
   logic [FI_W-1:0]       victim_ff, victim_in;
   logic [TOTAL_BITS-1:0] hit_ff, hit_in, miss_ff, miss_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   outcome_type           outcome_ff, outcome_in;
   logic [FI_W-1:0]       frame_ff, frame_in;
   logic                  evicted_ff, evicted_in;
   logic [KEY_BITS-1:0]   ev_key_ff, ev_key_in;
   logic                  ev_dirty_ff, ev_dirty_in;

   logic                hit;
   logic [FI_W-1:0]     hit_idx;
   logic                full;
   logic [FI_W-1:0]     first_empty;

   logic                load_en;
   logic [FI_W-1:0]     load_idx;
   list_op_type         list_op;
   logic [FI_W-1:0]     list_frame;
   logic [FI_W-1:0]     list_head, list_tail;
   logic                list_empty;
   logic [KEY_BITS-1:0] rd_key;
   logic                rd_dirty;

   // search all frames in parallel, find the lowest empty frame
   always_comb begin
      hit         = 1'b0;
      hit_idx     = '0;
      full        = 1'b1;
      first_empty = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && cam_ff[i] == key_ff) begin
            hit     = 1'b1;
            hit_idx = FI_W'(i);
         end
         if (!valid_ff[i]) begin
            full        = 1'b0;
            first_empty = FI_W'(i);
         end
      end
   end

   assign hand_next = (hand_ff == FI_W'(FRAMES - 1)) ? '0 : hand_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (hit || !exists_ff || !full) begin
               state_in = ST_IDLE;
            end else if (policy_ff == POL_CLOCK) begin
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_EV_READ;
            end
         end
         ST_SWEEP: begin
            if (!ref_ff[hand_ff]) begin
               state_in = ST_EV_READ;
            end
         end
         ST_EV_READ:  state_in = ST_EV_WRITE;
         ST_EV_WRITE: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         valid_in[i] = valid_ff[i];
         ref_in[i]   = ref_ff[i];
      end
      hand_in      = hand_ff;
      victim_in    = victim_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      load_en      = 1'b0;
      load_idx     = first_empty;
      list_op      = LIST_NONE;
      list_frame   = hit_idx;
      rsp_valid_in = 1'b0;
      outcome_in   = outcome_ff;
      frame_in     = frame_ff;
      evicted_in   = evicted_ff;
      ev_key_in    = ev_key_ff;
      ev_dirty_in  = ev_dirty_ff;
      case (state_ff)
         ST_LOOKUP: begin
            outcome_in  = OUT_HIT;
            frame_in    = '0;
            evicted_in  = 1'b0;
            ev_key_in   = '0;
            ev_dirty_in = 1'b0;
            if (hit) begin
               hit_in       = hit_ff + 1'b1;
               rsp_valid_in = 1'b1;
               frame_in     = hit_idx;
               if (policy_ff == POL_LRU || policy_ff == POL_MRU) begin
                  list_op = LIST_APPEND;
               end else if (policy_ff == POL_CLOCK) begin
                  ref_in[hit_idx] = 1'b1;
               end
            end else begin
               miss_in = miss_ff + 1'b1;
               if (!exists_ff) begin
                  rsp_valid_in = 1'b1;
                  outcome_in   = OUT_NOT_FOUND;
               end else if (!full) begin
                  rsp_valid_in = 1'b1;
                  outcome_in   = OUT_LOADED;
                  frame_in     = first_empty;
                  load_en      = 1'b1;
               end else if (policy_ff != POL_CLOCK) begin
                  if (list_empty) begin
                     victim_in = '0;
                  end else if (policy_ff == POL_MRU) begin
                     victim_in = list_tail;
                  end else begin
                     victim_in = list_head;
                  end
               end
            end
         end
         ST_SWEEP: begin
            hand_in = hand_next;
            if (ref_ff[hand_ff]) begin
               ref_in[hand_ff] = 1'b0;
            end else begin
               victim_in = hand_ff;
            end
         end
         ST_EV_WRITE: begin
            rsp_valid_in = 1'b1;
            outcome_in   = OUT_LOADED;
            frame_in     = victim_ff;
            evicted_in   = 1'b1;
            ev_key_in    = rd_key;
            ev_dirty_in  = rd_dirty;
            load_en      = 1'b1;
            load_idx     = victim_ff;
            list_frame   = victim_ff;
            list_op      = LIST_REMOVE;
         end
         default: begin
         end
      endcase
      // a load marks the frame valid and referenced and, unless the policy is CLOCK, enters the list
      if (load_en) begin
         valid_in[load_idx] = 1'b1;
         ref_in[load_idx]   = 1'b1;
         if (policy_ff != POL_CLOCK) begin
            list_op    = LIST_APPEND;
            list_frame = load_idx;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POL_FIFO;
         hand_ff      <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
            ref_ff[i]   <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            policy_ff <= policy_type'(csr_wdata);
         end
         for (int i = 0; i < FRAMES; i++) begin
            valid_ff[i] <= valid_in[i];
            ref_ff[i]   <= ref_in[i];
         end
      end
   end

   // payload: request beat, match keys, result fields
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         key_ff    <= req_page_key;
         exists_ff <= req_page_exists;
         dirty_ff  <= req_dirty_mark;
      end
      if (load_en) begin
         cam_ff[load_idx] <= key_ff;
      end
      victim_ff   <= victim_in;
      outcome_ff  <= outcome_in;
      frame_ff    <= frame_in;
      evicted_ff  <= evicted_in;
      ev_key_ff   <= ev_key_in;
      ev_dirty_ff <= ev_dirty_in;
   end

   bpr_frame_store #(
      .FRAMES   (FRAMES),
      .KEY_BITS (KEY_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (load_en),
      .wr_addr  (load_idx),
      .wr_key   (key_ff),
      .wr_dirty (dirty_ff),
      .rd_addr  (victim_ff),
      .rd_key   (rd_key),
      .rd_dirty (rd_dirty)
   );

   bpr_order_list #(
      .FRAMES (FRAMES)
   ) u_list (
      .clock (clock),
      .reset (reset),
      .op    (list_op),
      .frame (list_frame),
      .head  (list_head),
      .tail  (list_tail),
      .empty (list_empty)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = outcome_ff;
   assign rsp_frame_index   = frame_ff;
   assign rsp_evicted       = evicted_ff;
   assign rsp_evicted_key   = ev_key_ff;
   assign rsp_evicted_dirty = ev_dirty_ff;
   assign rsp_hit_total     = hit_ff;
   assign rsp_miss_total    = miss_ff;

endmodule

/* rtl/bpr_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpr_checker
   import bpr_pkg::*;
#(
   parameter int FRAMES = FRAMES_DEF,
   localparam int FI_W  = $clog2(FRAMES)
) (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_valid,
   input logic [1:0]      rsp_outcome,
   input logic [FI_W-1:0] rsp_frame_index,
   input logic            rsp_evicted
);

   // an accepted beat always raises busy in the next cycle
   `BPR_ASSERT(a_start_busy, start && !busy |=> busy, "accepted beat did not raise busy")
   // a result only follows a busy cycle
   `BPR_ASSERT(a_rsp_after_busy, rsp_valid |-> $past(busy), "result without work")
   // a hit never evicts
   `BPR_ASSERT(a_hit_no_evict, rsp_valid && rsp_outcome == OUT_HIT |-> !rsp_evicted, "hit evicted")
   // not-found reports frame zero and no eviction
   `BPR_ASSERT(a_nf_fields, rsp_valid && rsp_outcome == OUT_NOT_FOUND |-> rsp_frame_index == '0 && !rsp_evicted, "not-found fields")

endmodule

bind buffer_pool_replacement bpr_checker #(.FRAMES(FRAMES)) u_bpr_checker (.*);
